// File: src/sensor_window_phase_classifier_assert.svh
// Assertion helpers for the phase classifier.
`ifndef SENSOR_WINDOW_PHASE_CLASSIFIER_ASSERT_SVH
`define SENSOR_WINDOW_PHASE_CLASSIFIER_ASSERT_SVH

// Same-cycle implication.
`define SWPC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define SWPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/swpc_pkg.sv
`timescale 1ns / 1ps
package swpc_pkg;

	localparam int TEMP_W    = 12;
	localparam int GAS_W     = 16;
	localparam int PCT_W     = 7;
	localparam int AMB_W     = 11;
	localparam int MINR_W    = 5;
	localparam int PHASE_W   = 3;
	localparam int CN_W      = 13;
	localparam int ALERT_W   = 5;
	localparam int CFG_IDX_W = 1;

	localparam int SHORT_WIN = 12;
	localparam int LONG_WIN  = 24;
	localparam int BACK_W    = 5;
	localparam int SUM_W     = 24;
	localparam int NUM_W     = 22;
	localparam int DEN_W     = 9;
	localparam int DIV_STEPS = 13;

	localparam logic [CFG_IDX_W-1:0] REG_AMBIENT      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_READINGS = 1'b1;

	typedef enum logic [PHASE_W-1:0] {
		PH_MESO    = 3'd0,
		PH_THERMO  = 3'd1,
		PH_COOL    = 3'd2,
		PH_MATURE  = 3'd3,
		PH_CURED   = 3'd4,
		PH_DORMANT = 3'd5
	} phase_t;

	typedef struct packed {
		logic              store;
		logic              clear;
		logic              rd;
		logic [BACK_W-1:0] back;
		logic              classify;
		logic              div_step;
		logic              publish;
	} cmd_t;

	typedef struct packed {
		logic              emit;
		logic [BACK_W-1:0] len;
	} status_t;

endpackage

// File: src/swpc_ram.sv
`timescale 1ns / 1ps
module swpc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/swpc_dp.sv
`timescale 1ns / 1ps
module swpc_dp #(
	parameter int HISTORY_DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  swpc_pkg::cmd_t                        cmd,
	output swpc_pkg::status_t                     status,
	input  logic                                  cfg_wr_en,
	input  logic [swpc_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [swpc_pkg::AMB_W-1:0]            cfg_wdata,
	input  logic signed [swpc_pkg::TEMP_W-1:0]    temp_center_tenths,
	input  logic [swpc_pkg::PCT_W-1:0]            moisture_center_pct,
	input  logic [swpc_pkg::GAS_W-1:0]            co2_ppm_in,
	input  logic [swpc_pkg::GAS_W-1:0]            methane_ppm_in,
	input  logic [swpc_pkg::PCT_W-1:0]            battery_pct_in,
	output logic [swpc_pkg::PHASE_W-1:0]          phase_code,
	output logic [swpc_pkg::CN_W-1:0]             cn_ratio_tenths,
	output logic [swpc_pkg::ALERT_W-1:0]          alert_mask
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int SW = swpc_pkg::SUM_W;
	localparam int DSH_W = swpc_pkg::DEN_W + swpc_pkg::DIV_STEPS - 1;

	function automatic logic signed [SW-1:0] mulc(input logic signed [SW-1:0] n, input int k);
		mulc = SW'(n * k);
	endfunction

	// config
	logic signed [swpc_pkg::AMB_W-1:0] amb_q;
	logic [swpc_pkg::MINR_W-1:0]       min_q;

	// history bookkeeping
	logic [AW-1:0] wp_q;
	logic [CW-1:0] count_q;

	// read pipeline
	logic                        rd_s1;
	logic [swpc_pkg::BACK_W-1:0] back_s1;

	logic [AW+1:0]                     raw_addr;
	logic [AW-1:0]                     raddr;
	logic signed [swpc_pkg::TEMP_W-1:0] t_rd;
	logic [swpc_pkg::GAS_W-1:0]        c_rd;
	logic [swpc_pkg::GAS_W-1:0]        m_rd;

	logic signed [SW-1:0] t12_q, c12_q, m12_q, t24_q, c24_q, m24_q;
	logic signed [SW-1:0] t_ext, c_ext, m_ext;

	logic [swpc_pkg::ALERT_W-1:0] alert_q;
	swpc_pkg::phase_t             phase_q;

	logic [swpc_pkg::NUM_W-1:0]   rem_q;
	logic [DSH_W-1:0]             dsh_q;
	logic [swpc_pkg::CN_W-1:0]    quo_q;

	// classify terms
	logic [swpc_pkg::BACK_W-1:0] n12, n24;
	logic signed [SW-1:0] nn12, nn24, dt, dc, told, cold, amb_lim, amb_prod, capped, num;
	logic [swpc_pkg::DEN_W-1:0] den;
	swpc_pkg::phase_t phase_d;
	logic slope_ok;
	logic [swpc_pkg::ALERT_W-1:0] alert_d;

	always_comb begin
		raw_addr = (AW+2)'(wp_q) + (AW+2)'(HISTORY_DEPTH - 1) - (AW+2)'(cmd.back);
		if (raw_addr >= (AW+2)'(HISTORY_DEPTH)) begin
			raddr = AW'(raw_addr - (AW+2)'(HISTORY_DEPTH));
		end else begin
			raddr = AW'(raw_addr);
		end
	end

	swpc_ram #(.WIDTH(swpc_pkg::TEMP_W), .DEPTH(HISTORY_DEPTH)) u_temp_ram (
		.clk(clk), .we(cmd.store), .waddr(wp_q), .wdata(temp_center_tenths),
		.raddr(raddr), .rdata(t_rd)
	);
	swpc_ram #(.WIDTH(swpc_pkg::GAS_W), .DEPTH(HISTORY_DEPTH)) u_co2_ram (
		.clk(clk), .we(cmd.store), .waddr(wp_q), .wdata(co2_ppm_in),
		.raddr(raddr), .rdata(c_rd)
	);
	swpc_ram #(.WIDTH(swpc_pkg::GAS_W), .DEPTH(HISTORY_DEPTH)) u_meth_ram (
		.clk(clk), .we(cmd.store), .waddr(wp_q), .wdata(methane_ppm_in),
		.raddr(raddr), .rdata(m_rd)
	);

	assign t_ext = {{(SW-swpc_pkg::TEMP_W){t_rd[swpc_pkg::TEMP_W-1]}}, t_rd};
	assign c_ext = {{(SW-swpc_pkg::GAS_W){1'b0}}, c_rd};
	assign m_ext = {{(SW-swpc_pkg::GAS_W){1'b0}}, m_rd};

	assign status.emit = count_q >= CW'(min_q);
	assign status.len  = n24;

	always_comb begin
		alert_d[0] = methane_ppm_in > swpc_pkg::GAS_W'(1000);
		alert_d[1] = temp_center_tenths > swpc_pkg::TEMP_W'(700);
		alert_d[2] = battery_pct_in < swpc_pkg::PCT_W'(20);
		alert_d[3] = moisture_center_pct > swpc_pkg::PCT_W'(70);
		alert_d[4] = (moisture_center_pct != '0) && (moisture_center_pct < swpc_pkg::PCT_W'(30));
	end

	always_comb begin
		n12 = (count_q >= CW'(swpc_pkg::SHORT_WIN)) ? swpc_pkg::BACK_W'(swpc_pkg::SHORT_WIN)
			: swpc_pkg::BACK_W'(count_q);
		n24 = (count_q >= CW'(swpc_pkg::LONG_WIN)) ? swpc_pkg::BACK_W'(swpc_pkg::LONG_WIN)
			: swpc_pkg::BACK_W'(count_q);
		nn12 = {{(SW-swpc_pkg::BACK_W){1'b0}}, n12};
		nn24 = {{(SW-swpc_pkg::BACK_W){1'b0}}, n24};
		slope_ok = count_q >= CW'(swpc_pkg::LONG_WIN);
		told = t24_q - t12_q;
		cold = c24_q - c12_q;
		dt = slope_ok ? t12_q - told : '0;
		dc = slope_ok ? c12_q - cold : '0;

		if (t12_q < mulc(nn12, 50) && c12_q < mulc(nn12, 200)) begin
			phase_d = swpc_pkg::PH_DORMANT;
		end else if (t12_q > mulc(nn12, 500) && c12_q > mulc(nn12, 1000)) begin
			phase_d = swpc_pkg::PH_THERMO;
		end else if (t12_q > mulc(nn12, 300) && t12_q < mulc(nn12, 550)
				&& dt < -SW'(60) && dc < -SW'(120)) begin
			phase_d = swpc_pkg::PH_COOL;
		end else if (t12_q < mulc(nn12, 300) && t12_q > mulc(nn12, 120)
				&& c12_q < mulc(nn12, 800) && dc < SW'(60)) begin
			phase_d = swpc_pkg::PH_MATURE;
		end else if (t12_q < mulc(nn12, 250) && c12_q < mulc(nn12, 300)
				&& m12_q < mulc(nn12, 50)) begin
			phase_d = swpc_pkg::PH_CURED;
		end else begin
			phase_d = swpc_pkg::PH_MESO;
		end

		// fixed answers go through the divider with a divisor of one
		amb_lim  = {{(SW-swpc_pkg::AMB_W){amb_q[swpc_pkg::AMB_W-1]}}, amb_q} + SW'(30);
		amb_prod = amb_lim * nn24;
		capped   = (m24_q < mulc(nn24, 1000)) ? m24_q : mulc(nn24, 1000);
		if (m24_q > mulc(nn24, 500)) begin
			num = mulc(nn24, 1300) - capped;
			den = swpc_pkg::DEN_W'(n24) << 1;
		end else if (c24_q > mulc(nn24, 2000) && t24_q > mulc(nn24, 400)) begin
			num = SW'(280);
			den = swpc_pkg::DEN_W'(1);
		end else if (c24_q < mulc(nn24, 300)) begin
			num = (t24_q < amb_prod) ? SW'(200) : SW'(450);
			den = swpc_pkg::DEN_W'(1);
		end else begin
			num = mulc(nn24, 4800) + c24_q;
			den = swpc_pkg::DEN_W'(mulc(nn24, 17));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amb_q   <= swpc_pkg::AMB_W'(200);
			min_q   <= swpc_pkg::MINR_W'(8);
			wp_q    <= '0;
			count_q <= '0;
			rd_s1   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_addr)
					swpc_pkg::REG_AMBIENT:      amb_q <= cfg_wdata;
					swpc_pkg::REG_MIN_READINGS: min_q <= cfg_wdata[swpc_pkg::MINR_W-1:0];
					default: ;
				endcase
			end
			if (cmd.store) begin
				wp_q <= (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				if (count_q < CW'(HISTORY_DEPTH)) begin
					count_q <= count_q + 1'b1;
				end
			end
			rd_s1 <= cmd.rd;
		end
	end

	always_ff @(posedge clk) begin
		back_s1 <= cmd.back;
		if (cmd.store) begin
			alert_q <= alert_d;
		end
		if (cmd.clear) begin
			t12_q <= '0; c12_q <= '0; m12_q <= '0;
			t24_q <= '0; c24_q <= '0; m24_q <= '0;
		end else if (rd_s1) begin
			t24_q <= t24_q + t_ext;
			c24_q <= c24_q + c_ext;
			m24_q <= m24_q + m_ext;
			if (back_s1 < swpc_pkg::BACK_W'(swpc_pkg::SHORT_WIN)) begin
				t12_q <= t12_q + t_ext;
				c12_q <= c12_q + c_ext;
				m12_q <= m12_q + m_ext;
			end
		end
		if (cmd.classify) begin
			phase_q <= phase_d;
			rem_q   <= swpc_pkg::NUM_W'(num);
			dsh_q   <= {den, {(swpc_pkg::DIV_STEPS-1){1'b0}}};
			quo_q   <= '0;
		end else if (cmd.div_step) begin
			if ({1'b0, dsh_q} <= rem_q) begin
				rem_q <= rem_q - {1'b0, dsh_q};
				quo_q <= {quo_q[swpc_pkg::CN_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[swpc_pkg::CN_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.publish) begin
			phase_code      <= phase_q;
			cn_ratio_tenths <= quo_q;
			alert_mask      <= alert_q;
		end
	end

endmodule

// File: src/swpc_ctrl.sv
`timescale 1ns / 1ps
module swpc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  swpc_pkg::status_t status,
	output swpc_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_WALK, S_DRAIN, S_CLASS, S_DIV, S_DONE
	} state_t;

	state_t                      state_q;
	logic [swpc_pkg::BACK_W-1:0] cnt_q;
	logic                        out_valid_q;
	logic                        slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.store    = in_valid && (state_q == S_IDLE);
		cmd.clear    = (state_q == S_CHECK);
		cmd.rd       = (state_q == S_WALK);
		cmd.back     = cnt_q;
		cmd.classify = (state_q == S_CLASS);
		cmd.div_step = (state_q == S_DIV);
		cmd.publish  = (state_q == S_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					cnt_q   <= '0;
					state_q <= status.emit ? S_WALK : S_IDLE;
				end
				S_WALK: begin
					if (cnt_q == status.len - 1'b1) begin
						cnt_q   <= '0;
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DRAIN: state_q <= S_CLASS;
				S_CLASS: state_q <= S_DIV;
				S_DIV: begin
					if (cnt_q == swpc_pkg::BACK_W'(swpc_pkg::DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DONE: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: src/sensor_window_phase_classifier.sv
// One reading per beat. A reading whose stored count is still below min_readings
// is absorbed with no result. Otherwise, with n = min(stored readings, 24),
// the newest n entries of the ring history are walked one entry per cycle through
// a single read port, then the phase is classified and the C:N estimate
// comes from a 13-step shift-subtract divider. A result waiting at the output
// holds the block in its final state until it is taken.
`timescale 1ns / 1ps
`include "sensor_window_phase_classifier_assert.svh"
module sensor_window_phase_classifier #(
	parameter int HISTORY_DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [swpc_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [swpc_pkg::AMB_W-1:0]            cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [swpc_pkg::TEMP_W-1:0]    temp_center_tenths,
	input  logic [swpc_pkg::PCT_W-1:0]            moisture_center_pct,
	input  logic [swpc_pkg::GAS_W-1:0]            co2_ppm_in,
	input  logic [swpc_pkg::GAS_W-1:0]            methane_ppm_in,
	input  logic [swpc_pkg::PCT_W-1:0]            battery_pct_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [swpc_pkg::PHASE_W-1:0]          phase_code,
	output logic [swpc_pkg::CN_W-1:0]             cn_ratio_tenths,
	output logic [swpc_pkg::ALERT_W-1:0]          alert_mask
);

	swpc_pkg::cmd_t    cmd;
	swpc_pkg::status_t status;

	swpc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .cmd(cmd)
	);

	swpc_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .status(status),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.temp_center_tenths(temp_center_tenths),
		.moisture_center_pct(moisture_center_pct),
		.co2_ppm_in(co2_ppm_in),
		.methane_ppm_in(methane_ppm_in),
		.battery_pct_in(battery_pct_in),
		.phase_code(phase_code),
		.cn_ratio_tenths(cn_ratio_tenths),
		.alert_mask(alert_mask)
	);

	`SWPC_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready)
	`SWPC_ASSERT_NOW(a_publish_slot_free, cmd.publish, !out_valid || out_ready)
	`SWPC_ASSERT_NOW(a_phase_legal, out_valid, phase_code != 3'd6 && phase_code != 3'd7)
	`SWPC_ASSERT_NOW(a_cn_range, out_valid, cn_ratio_tenths <= 13'd4200)

endmodule
